// ----- sv/assert_macros.svh -----
// Assertion macros for the line editor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SLE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define SLE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sle_pkg.sv -----
// Package of the serial line editor: sizes, key codes, result kinds, control types.
`default_nettype none
package sle_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int CNT_W         = $clog2(LINE_CAPACITY);

    localparam logic [7:0] KEY_BACKSPACE = 8'h08;
    localparam logic [7:0] KEY_DELETE    = 8'h7F;
    localparam logic [7:0] KEY_UP_FINAL  = 8'h41;
    localparam logic [7:0] KEY_ESC       = 8'h1B;
    localparam logic [7:0] KEY_BRACKET   = 8'h5B;
    localparam logic [7:0] KEY_LF        = 8'h0A;
    localparam logic [7:0] KEY_CR        = 8'h0D;
    localparam logic [7:0] KEY_SPACE     = 8'h20;

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        EMIT_ECHO,
        EMIT_SPACE,
        EMIT_BS,
        EMIT_LF,
        EMIT_CR,
        EMIT_CHAR,
        EMIT_END
    } emit_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_PREV,
        ST_RD_LAST,
        ST_ECHO,
        ST_LINE_CHAR,
        ST_LINE_END,
        ST_ERASE_SP,
        ST_ERASE_BS,
        ST_UP_LF,
        ST_UP_CR
    } ctrl_state_t;

    typedef struct packed {
        logic      accept;
        logic      idx_inc;
        logic      idx_clr;
        logic      chk_esc;
        logic      chk_bkt;
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_last;
        logic      cnt_store;
        logic      cnt_dec;
        logic      cnt_clr;
    } sle_cmd_t;

    typedef struct packed {
        logic is_end;
        logic is_erase;
        logic up_hit;
        logic cnt_zero;
        logic can_store;
        logic last_char;
        logic out_free;
    } sle_sts_t;

endpackage
`default_nettype wire

// ----- sv/sle_if.sv -----
// Channel interfaces of the line editor: received bytes and result items.
`default_nettype none
interface sle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sle_result_if;
    logic            valid;
    logic            ready;
    sle_pkg::kind_t  kind;
    logic [7:0]      data_byte;
    logic [4:0]      line_length;
    logic            last;

    modport source (output valid, output kind, output data_byte, output line_length,
                    output last, input ready);
    modport sink (input valid, input kind, input data_byte, input line_length,
                  input last, output ready);
endinterface
`default_nettype wire

// ----- sv/sle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- sv/sle_ctrl.sv -----
// Line editor controller: sequences reads, echoes and line output per received byte.
`default_nettype none
module sle_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rx_valid,
    output logic                   rx_ready,
    input  wire sle_pkg::sle_sts_t sts,
    output sle_pkg::sle_cmd_t      cmd
);
    import sle_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit_sel = EMIT_ECHO;
        rx_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                rx_ready = 1'b1;
                if (rx_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_RD_PREV;
                end
            end
            ST_RD_PREV:
            begin
                // data of the second-to-last entry arrives; request the last one
                cmd.chk_esc = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = ST_RD_LAST;
            end
            ST_RD_LAST:
            begin
                cmd.chk_bkt = 1'b1;
                state_next  = ST_ECHO;
            end
            ST_ECHO:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_ECHO;
                    cmd.emit_last = !(sts.is_end || (sts.is_erase && !sts.cnt_zero)
                                      || sts.up_hit);
                    if (sts.is_end)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = sts.cnt_zero ? ST_LINE_END : ST_LINE_CHAR;
                    end
                    else if (sts.is_erase)
                    begin
                        state_next = sts.cnt_zero ? ST_IDLE : ST_ERASE_SP;
                    end
                    else if (sts.up_hit)
                    begin
                        state_next = ST_UP_LF;
                    end
                    else
                    begin
                        // store while there is room, drop otherwise
                        cmd.cnt_store = sts.can_store;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_LINE_CHAR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_CHAR;
                    cmd.idx_inc  = 1'b1;
                    if (sts.last_char)
                    begin
                        state_next = ST_LINE_END;
                    end
                end
            end
            ST_LINE_END:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_END;
                    cmd.emit_last = 1'b1;
                    cmd.cnt_clr   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_ERASE_SP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_SPACE;
                    state_next   = ST_ERASE_BS;
                end
            end
            ST_ERASE_BS:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_BS;
                    cmd.emit_last = 1'b1;
                    cmd.cnt_dec   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_UP_LF:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_LF;
                    state_next   = ST_UP_CR;
                end
            end
            ST_UP_CR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_CR;
                    cmd.emit_last = 1'b1;
                    cmd.cnt_clr   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/sle_dp.sv -----
// Line editor datapath: byte and count registers, line store, result register.
`default_nettype none
`include "assert_macros.svh"
module sle_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        rx_byte,
    input  wire sle_pkg::sle_cmd_t cmd,
    output sle_pkg::sle_sts_t      sts,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output sle_pkg::kind_t         out_kind,
    output logic [7:0]             out_data,
    output logic [4:0]             out_length,
    output logic                   out_last
);
    import sle_pkg::*;

    logic [7:0]       byte_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             esc_ok_reg;
    logic             up_hit_reg;
    logic             out_valid_reg;
    kind_t            kind_reg;
    kind_t            kind_next;
    logic [7:0]       data_reg;
    logic [7:0]       data_next;
    logic [4:0]       length_reg;
    logic [4:0]       length_next;
    logic             last_reg;
    logic [7:0]       rdata;

    // read address runs one step ahead so rdata matches idx_reg
    always_comb
    begin
        if (cmd.accept)
        begin
            idx_next = cnt_reg - CNT_W'(2);
        end
        else if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_comb
    begin
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else if (cmd.cnt_store)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    sle_ram #(
        .WIDTH(8),
        .DEPTH(LINE_CAPACITY)
    ) u_line_store (
        .clk  (clk),
        .we   (cmd.cnt_store),
        .waddr(cnt_reg),
        .wdata(byte_reg),
        .raddr(idx_next),
        .rdata(rdata)
    );

    always_comb
    begin
        length_next = '0;
        unique case (cmd.emit_sel)
            EMIT_ECHO:
            begin
                kind_next = KIND_ECHO;
                data_next = byte_reg;
            end
            EMIT_SPACE:
            begin
                kind_next = KIND_ECHO;
                data_next = KEY_SPACE;
            end
            EMIT_BS:
            begin
                kind_next = KIND_ECHO;
                data_next = KEY_BACKSPACE;
            end
            EMIT_LF:
            begin
                kind_next = KIND_ECHO;
                data_next = KEY_LF;
            end
            EMIT_CR:
            begin
                kind_next = KIND_ECHO;
                data_next = KEY_CR;
            end
            EMIT_CHAR:
            begin
                kind_next = KIND_CHAR;
                data_next = rdata;
            end
            EMIT_END:
            begin
                kind_next   = KIND_END;
                data_next   = '0;
                length_next = 5'(cnt_reg);
            end
            default:
            begin
                kind_next = KIND_ECHO;
                data_next = byte_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            esc_ok_reg    <= 1'b0;
            up_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (cmd.chk_esc)
            begin
                esc_ok_reg <= (rdata == KEY_ESC);
            end
            if (cmd.accept)
            begin
                up_hit_reg <= 1'b0;
            end
            else if (cmd.chk_bkt)
            begin
                up_hit_reg <= esc_ok_reg && (rdata == KEY_BRACKET)
                              && (byte_reg == KEY_UP_FINAL) && (cnt_reg > CNT_W'(2));
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= rx_byte;
        end
        if (cmd.emit)
        begin
            kind_reg   <= kind_next;
            data_reg   <= data_next;
            length_reg <= length_next;
            last_reg   <= cmd.emit_last;
        end
    end

    always_comb
    begin
        sts.is_end    = (byte_reg == KEY_LF) || (byte_reg == KEY_CR);
        sts.is_erase  = (byte_reg == KEY_BACKSPACE) || (byte_reg == KEY_DELETE);
        sts.up_hit    = up_hit_reg;
        sts.cnt_zero  = (cnt_reg == '0);
        sts.can_store = (cnt_reg < CNT_W'(LINE_CAPACITY - 1));
        sts.last_char = ((idx_reg + CNT_W'(1)) == cnt_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = kind_reg;
    assign out_data   = data_reg;
    assign out_length = length_reg;
    assign out_last   = last_reg;

    `SLE_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= CNT_W'(LINE_CAPACITY - 1), "count beyond capacity")
    `SLE_ASSERT_IMPLY(a_no_overwrite, cmd.emit, !out_valid_reg || out_ready, "result overwritten")
    `SLE_ASSERT_IMPLY(a_char_in_line, cmd.emit && (cmd.emit_sel == EMIT_CHAR), idx_reg < cnt_reg, "line read past count")

endmodule
`default_nettype wire

// ----- sv/serial_line_editor_unit.sv -----
// Serial line editor: echoes received bytes, edits and releases terminal lines.
//
// Channels: rx carries one received byte per transfer; res carries result
// items (kind, data_byte, line_length, last), one or more per byte, the
// final one of each byte flagged by last. Both use valid/ready; a transfer
// happens on a rising edge with both high.
// Sequencing: a byte is taken only while the unit is idle. After the
// transfer the sequencer reads two line-store entries to check for
// ESC '[', then emits the echo into the output register, followed by any
// further results of that byte; a line end sends each stored character, read
// one by one through the single read port. At most 31 characters are stored.
// Reset: the character count clears; the line store is left unwritten and only
// entries below the count affect the results.
// Stall: when the receiver holds ready low the result stays in the output
// register and the sequencer waits before its next result; once the last
// result of a byte is held, the unit returns to idle and can take a byte.
`default_nettype none
module serial_line_editor_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sle_byte_if.sink     rx,
    sle_result_if.source res
);
    import sle_pkg::*;

    sle_cmd_t cmd;
    sle_sts_t sts;

    sle_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_valid(rx.valid),
        .rx_ready(rx.ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sle_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (rx.rx_byte),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (res.ready),
        .out_valid (res.valid),
        .out_kind  (res.kind),
        .out_data  (res.data_byte),
        .out_length(res.line_length),
        .out_last  (res.last)
    );

endmodule
`default_nettype wire
